// File: rtl/isort_pkg.sv
// Shared types and constants for the insertion sorter.
// No dependencies; used by insertion_sorter.sv in rtl/ and by the testbench.
package isort_pkg;

  localparam int DATA_W       = 32;
  localparam int CAPACITY_DEF = 32;

  // sequencer states, one-hot
  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_CMP   = 5'b00010,
    ST_WR    = 5'b00100,
    ST_OUT   = 5'b01000,
    ST_EMPTY = 5'b10000
  } state_t;

endpackage

// File: rtl/isort_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module isort_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/insertion_sorter.sv
// Insertion sorter top level: sequencer, shared comparator and output register.
// Depends on isort_pkg and isort_ram.
//
// Values come in one request at a time and are kept in ascending signed order in
// a RAM of CAPACITY entries. An insert walks the store from its top end down,
// one entry per cycle through a single comparator and the RAM's one read and
// one write port: every stored entry not smaller than the new value moves up
// one slot, then the value is written into the gap; in_ready is low while an
// insert is in progress. A value dropped on a full store is taken in ST_IDLE,
// which the sequencer does not leave, so in_ready stays high. A request
// with the end marker set drains the store in ascending order, one result per
// cycle while out_ready stays high, flags the last result with is_last, then
// empties the store; with nothing stored it gives a single result with empty_res
// set and a zero value. Values arriving while the store is full are dropped and
// every result of the next drain carries overflow. Results sit in an output
// register, so a result may still wait on out_ready while the block goes on. No
// clearing pass: count alone tells which entries are live.
module insertion_sorter #(
  parameter int CAPACITY = isort_pkg::CAPACITY_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [isort_pkg::DATA_W-1:0] value,
  input  logic                                is_end,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [isort_pkg::DATA_W-1:0] sorted_value,
  output logic                                is_last,
  output logic                                empty_res,
  output logic                                overflow
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  isort_pkg::state_t state, state_next;

  logic [CW-1:0] count, count_next;
  logic [CW-1:0] idx, idx_next;
  logic          dropped, dropped_next;
  logic signed [isort_pkg::DATA_W-1:0] val;

  // RAM port signals
  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  logic [isort_pkg::DATA_W-1:0] ram_wdata;
  logic [AW-1:0]               ram_raddr;
  logic [isort_pkg::DATA_W-1:0] ram_rdata;

  // output register load
  logic                        out_load;
  logic [isort_pkg::DATA_W-1:0] out_value_next;
  logic                        out_last_next;
  logic                        out_empty_next;

  logic          in_fire;
  logic          out_free;
  logic          lt;
  logic [CW-1:0] count_m1, idx_m1, idx_m2, idx_p1;
  logic          run_last;

  assign in_ready = (state == isort_pkg::ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // the one comparator: stored entry strictly below the new value
  assign lt = $signed(ram_rdata) < val;

  assign count_m1 = count - CW'(1);
  assign idx_m1   = idx - CW'(1);
  assign idx_m2   = idx - CW'(2);
  assign idx_p1   = idx + CW'(1);
  assign run_last = (idx_p1 == count);

  isort_ram #(
    .WIDTH(isort_pkg::DATA_W),
    .DEPTH(CAPACITY)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    state_next     = state;
    count_next     = count;
    idx_next       = idx;
    dropped_next   = dropped;
    ram_we         = 1'b0;
    ram_waddr      = idx[AW-1:0];
    ram_wdata      = val;
    ram_raddr      = idx[AW-1:0];
    out_load       = 1'b0;
    out_value_next = ram_rdata;
    out_last_next  = run_last;
    out_empty_next = 1'b0;

    case (state)
      isort_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (is_end) begin
            idx_next   = '0;
            ram_raddr  = '0;
            state_next = (count == '0) ? isort_pkg::ST_EMPTY : isort_pkg::ST_OUT;
          end else if (count == CW'(CAPACITY)) begin
            dropped_next = 1'b1;
          end else if (count == '0) begin
            idx_next   = '0;
            state_next = isort_pkg::ST_WR;
          end else begin
            // fetch the top entry; compare against it next cycle
            idx_next   = count;
            ram_raddr  = count_m1[AW-1:0];
            state_next = isort_pkg::ST_CMP;
          end
        end
      end

      isort_pkg::ST_CMP: begin
        // ram_rdata holds entry idx-1
        ram_we = 1'b1;
        if (lt) begin
          ram_wdata  = val;
          count_next = count + CW'(1);
          state_next = isort_pkg::ST_IDLE;
        end else begin
          ram_wdata = ram_rdata;
          idx_next  = idx_m1;
          if (idx == CW'(1)) begin
            state_next = isort_pkg::ST_WR;
          end else begin
            ram_raddr = idx_m2[AW-1:0];
          end
        end
      end

      isort_pkg::ST_WR: begin
        ram_we     = 1'b1;
        ram_wdata  = val;
        count_next = count + CW'(1);
        state_next = isort_pkg::ST_IDLE;
      end

      isort_pkg::ST_OUT: begin
        // ram_rdata holds entry idx; hold the read address while stalled
        if (out_free) begin
          out_load = 1'b1;
          if (run_last) begin
            count_next   = '0;
            dropped_next = 1'b0;
            state_next   = isort_pkg::ST_IDLE;
          end else begin
            idx_next  = idx_p1;
            ram_raddr = idx_p1[AW-1:0];
          end
        end
      end

      isort_pkg::ST_EMPTY: begin
        out_value_next = '0;
        out_last_next  = 1'b1;
        out_empty_next = 1'b1;
        if (out_free) begin
          out_load     = 1'b1;
          dropped_next = 1'b0;
          state_next   = isort_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = isort_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= isort_pkg::ST_IDLE;
      count     <= '0;
      dropped   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      dropped <= dropped_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers, no reset
  always_ff @(posedge clk) begin
    idx <= idx_next;
    if (in_fire) begin
      val <= value;
    end
    if (out_load) begin
      sorted_value <= out_value_next;
      is_last      <= out_last_next;
      empty_res    <= out_empty_next;
      overflow     <= dropped;
    end
  end

  // store never holds more than CAPACITY entries
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("stored count above capacity");

  // an end marker always starts a drain
  a_end_drain: assert property (@(posedge clk) disable iff (rst)
    (in_fire && is_end) |=> (state == isort_pkg::ST_OUT || state == isort_pkg::ST_EMPTY))
    else $error("end marker did not start a drain");

  // empty result is a single, last, zero-valued result
  a_empty_form: assert property (@(posedge clk) disable iff (rst)
    (out_valid && empty_res) |-> (is_last && sorted_value == '0))
    else $error("malformed empty result");

  // an insert that ends with its write in ST_WR grows the count by exactly one
  a_insert_grow: assert property (@(posedge clk) disable iff (rst)
    (state == isort_pkg::ST_WR) |=> (count == $past(count) + CW'(1)))
    else $error("insert did not grow the store");

endmodule

// File: sim/insertion_sorter_tb.sv
// Self-checking testbench for insertion_sorter: directed table, then random sets.
// Depends on isort_pkg and the RTL in rtl/ (isort_ram, insertion_sorter).
`timescale 1ns / 1ps

module insertion_sorter_tb;

  localparam int DATA_W       = isort_pkg::DATA_W;
  localparam int CAPACITY     = isort_pkg::CAPACITY_DEF;
  localparam int RANDOM_ITEMS = 220;
  localparam int HOLD_CYCLES  = 300;   // long receiver hold-off under pressure
  localparam int HANG_LIMIT   = 4000;  // cycles with no handshake on either side
  localparam int DRAIN_TAIL   = CAPACITY + 8;

  localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  // one result of an output run
  typedef struct packed {
    logic signed [DATA_W-1:0] val;
    logic                     last;
    logic                     empty;
    logic                     ovf;
  } sort_result_t;

  // directed row: request fields plus an optional hand-written expectation
  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     is_end;
    logic                     typed;
    sort_result_t             exp;
  } dir_row_t;

  localparam sort_result_t NO_RES    = '0;
  localparam sort_result_t EMPTY_RES = '{32'sd0, 1'b1, 1'b1, 1'b0};

  // Typed rows are end markers whose single result is obvious: an empty run,
  // or a run holding one extreme value.
  localparam dir_row_t DIRECTED [18] = '{
    '{32'sd0,          1'b1, 1'b1, EMPTY_RES},                   // empty run after reset
    '{VAL_MIN,         1'b0, 1'b0, NO_RES},
    '{32'sd0,          1'b1, 1'b1, '{VAL_MIN, 1'b1, 1'b0, 1'b0}},
    '{VAL_MAX,         1'b0, 1'b0, NO_RES},
    '{32'sd0,          1'b1, 1'b1, '{VAL_MAX, 1'b1, 1'b0, 1'b0}},
    '{32'sd0,          1'b0, 1'b0, NO_RES},
    '{-32'sd1,         1'b0, 1'b0, NO_RES},
    '{32'sd1,          1'b0, 1'b0, NO_RES},
    '{VAL_MAX,         1'b0, 1'b0, NO_RES},
    '{VAL_MIN,         1'b0, 1'b0, NO_RES},
    '{-32'sd1,         1'b0, 1'b0, NO_RES},                      // duplicate
    '{32'sh5a5a_a5a5,  1'b1, 1'b0, NO_RES},                      // value ignored on end
    '{-32'sd7,         1'b1, 1'b1, EMPTY_RES},                   // empty again after run
    '{32'sd7,          1'b0, 1'b0, NO_RES},
    '{32'sd7,          1'b0, 1'b0, NO_RES},
    '{32'sd7,          1'b0, 1'b0, NO_RES},
    '{VAL_MIN + 32'sd1, 1'b0, 1'b0, NO_RES},
    '{32'sd0,          1'b1, 1'b0, NO_RES}
  };

  logic                     clk;
  logic                     rst          = 1'b1;
  logic                     in_valid     = 1'b0;
  logic                     in_ready;
  logic signed [DATA_W-1:0] value        = '0;
  logic                     is_end       = 1'b0;
  logic                     out_valid;
  logic                     out_ready    = 1'b0;
  logic signed [DATA_W-1:0] sorted_value;
  logic                     is_last;
  logic                     empty_res;
  logic                     overflow;

  // predictor state
  logic signed [DATA_W-1:0] model_store [CAPACITY];
  int                       model_count   = 0;
  logic                     model_dropped = 1'b0;
  sort_result_t             pending_results [$];

  int   error_count    = 0;
  int   requests_sent  = 0;
  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  int   quiet_cycles   = 0;
  int   hold_left      = 0;
  logic hold_trigger   = 1'b0;
  logic hold_seen      = 1'b0;

  insertion_sorter #(.CAPACITY(CAPACITY)) dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .value        (value),
    .is_end       (is_end),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .sorted_value (sorted_value),
    .is_last      (is_last),
    .empty_res    (empty_res),
    .overflow     (overflow)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Advance the sorted-store model by one accepted request and queue the
  // results it causes. A typed expectation replaces the predicted one.
  task automatic predict_request(input logic signed [DATA_W-1:0] v, input logic e,
                                 input logic typed, input sort_result_t typed_res);
    int           pos;
    sort_result_t r;
    if (!e) begin
      if (model_count >= CAPACITY) begin
        model_dropped = 1'b1;          // full store: drop, keep contents
      end else begin
        // place before the first stored value that is not smaller
        pos = 0;
        while (pos < model_count && model_store[pos] < v) pos++;
        for (int k = model_count; k > pos; k--) model_store[k] = model_store[k-1];
        model_store[pos] = v;
        model_count++;
      end
    end else begin
      if (typed) begin
        pending_results.push_back(typed_res);
      end else if (model_count == 0) begin
        r = '{32'sd0, 1'b1, 1'b1, model_dropped};
        pending_results.push_back(r);
      end else begin
        for (int k = 0; k < model_count; k++) begin
          r = '{model_store[k], (k == model_count - 1), 1'b0, model_dropped};
          pending_results.push_back(r);
        end
      end
      model_count   = 0;
      model_dropped = 1'b0;
    end
  endtask

  // Offer one request after a random idle gap; returns at the accepting edge.
  // in_valid is only lowered in the gap, so back-to-back requests keep it high.
  task automatic send_request(input logic signed [DATA_W-1:0] v, input logic e,
                              input logic typed, input sort_result_t typed_res);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    value    <= v;
    is_end   <= e;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_request(v, e, typed, typed_res);
    requests_sent++;
  endtask

  // One set of inserts with random content, optionally closed by an end marker.
  // Values lean on extremes and a narrow band so duplicates show up often.
  task automatic send_set(input int len, input bit with_end);
    logic signed [DATA_W-1:0] v;
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(9))
        0:       v = VAL_MIN;
        1:       v = VAL_MAX;
        2, 3, 4: v = $signed($urandom_range(8)) - 32'sd4;
        default: v = $urandom;
      endcase
      send_request(v, 1'b0, 1'b0, NO_RES);
    end
    if (with_end) send_request($urandom, 1'b1, 1'b0, NO_RES);
  endtask

  // Sender pauses until every expected result has come back.
  task automatic wait_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // Receiver: random stalls per phase, plus one long hold-off counted here.
  always @(posedge clk) begin
    if (hold_trigger != hold_seen) begin
      hold_seen <= hold_trigger;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Result checker: every accepted result against the oldest expectation.
  always @(posedge clk) begin : check_results
    sort_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: sorted_value %0d is_last %0b", sorted_value, is_last);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (sorted_value !== want.val) begin
          $error("sorted_value: expected %0d, got %0d", want.val, sorted_value);
          error_count++;
        end
        if (is_last !== want.last) begin
          $error("is_last: expected %0b, got %0b", want.last, is_last);
          error_count++;
        end
        if (empty_res !== want.empty) begin
          $error("empty_res: expected %0b, got %0b", want.empty, empty_res);
          error_count++;
        end
        if (overflow !== want.ovf) begin
          $error("overflow: expected %0b, got %0b", want.ovf, overflow);
          error_count++;
        end
      end
    end
  end

  // Watchdog: too long without any handshake means the block hung.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles < HANG_LIMIT) begin
      quiet_cycles <= quiet_cycles + 1;
    end else begin
      $display("insertion_sorter test failed");
      $finish;
    end
  end

  initial begin
    int target;
    int len;
    int pick;
    bit with_end;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed table, no idling
    foreach (DIRECTED[i])
      send_request(DIRECTED[i].value, DIRECTED[i].is_end, DIRECTED[i].typed, DIRECTED[i].exp);
    wait_drain();

    // random phases: none, sender idle, receiver stalling, both light
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
        1:       begin send_idle_pct = 86; recv_stall_pct <= 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct <= 86; end
        default: begin send_idle_pct = 13; recv_stall_pct <= 13; end
      endcase

      if (ph == 0) begin
        // Fill the store, then hold the receiver off while the end marker
        // and the next set are offered: the drain backs up into in_ready.
        send_set(CAPACITY, 1'b0);
        hold_trigger <= ~hold_trigger;
        send_request(32'sd0, 1'b1, 1'b0, NO_RES);
        send_set(5, 1'b1);
      end

      target = requests_sent + RANDOM_ITEMS / 4;
      while (requests_sent < target) begin
        pick = $urandom_range(99);
        if (pick < 6)       len = 0;                                      // empty run
        else if (pick < 70) len = $urandom_range(8, 1);
        else if (pick < 85) len = $urandom_range(20, 9);
        else if (pick < 93) len = $urandom_range(CAPACITY, CAPACITY - 2); // near full
        else                len = $urandom_range(CAPACITY + 3, CAPACITY + 1); // drops
        with_end = ($urandom_range(9) != 0);   // some sets run into the next
        send_set(len, with_end);
      end
      send_request($urandom, 1'b1, 1'b0, NO_RES);
      wait_drain();
    end

    // nothing should trickle out after the last run
    repeat (DRAIN_TAIL) @(posedge clk);
    if (error_count == 0)
      $display("insertion_sorter test passed");
    else
      $display("insertion_sorter test failed");
    $finish;
  end

endmodule

// File: insertion_sorter.f
rtl/isort_pkg.sv
rtl/isort_ram.sv
rtl/insertion_sorter.sv
sim/insertion_sorter_tb.sv
